/* rtl/core/kmve_pkg.sv */
// ----------------------------------------------------------------------------
// kmve_pkg
// Shared types and constants of the key match and value extract unit.
// ----------------------------------------------------------------------------
package kmve_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int LEN_W           = 5;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 64;
  localparam int KEY_W           = 128;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_DATA         = 2'd0,
    KIND_DONE         = 2'd1,
    KIND_NOT_FOUND    = 2'd2,
    KIND_UNTERMINATED = 2'd3
  } kind_t;

  // byte travelling along the window row
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } cell_link_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic [7:0] value_byte;
    kind_t      kind;
    logic       final_res;
  } result_t;

endpackage

/* rtl/core/kmve_in_if.sv */
// ----------------------------------------------------------------------------
// kmve_in_if
// Text byte channel: valid/ready with one character and its end mark.
// ----------------------------------------------------------------------------
interface kmve_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

/* rtl/core/kmve_out_if.sv */
// ----------------------------------------------------------------------------
// kmve_out_if
// Result channel: valid/ready with extracted byte, result kind and final flag.
// ----------------------------------------------------------------------------
interface kmve_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic [1:0] kind;
  logic       final_res;

  modport source (output valid, output value_byte, output kind, output final_res,
                  input ready);
  modport sink   (input valid, input value_byte, input kind, input final_res,
                  output ready);
endinterface

/* rtl/core/kmve_cell.sv */
// ----------------------------------------------------------------------------
// kmve_cell
// One window position: holds a byte, passes it on, compares the arriving byte.
// ----------------------------------------------------------------------------
module kmve_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  kmve_pkg::cell_ctrl_t ctrl,
  input  kmve_pkg::cell_link_t link_in,
  input  logic                 active,
  input  logic [7:0]           key_byte,
  output kmve_pkg::cell_link_t link_out,
  output logic                 hit
);

  logic       vld;
  logic [7:0] data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctrl.clear) begin
      vld <= 1'b0;
    end else if (ctrl.shift) begin
      vld <= link_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= link_in.data;
    end
  end

  assign link_out.vld  = vld;
  assign link_out.data = data;

  // compare on the byte this cell will hold after the shift
  assign hit = !active || (link_in.vld && (link_in.data == key_byte));

endmodule

/* rtl/core/kmve_chain.sv */
// ----------------------------------------------------------------------------
// kmve_chain
// Row of window cells, newest byte at cell 0, with the key match reduction.
// ----------------------------------------------------------------------------
module kmve_chain #(
  parameter int MAX_PATTERN = kmve_pkg::MAX_PATTERN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  kmve_pkg::cell_ctrl_t       ctrl,
  input  logic [7:0]                 text_byte,
  input  logic [kmve_pkg::KEY_W-1:0] pattern,
  input  logic [kmve_pkg::LEN_W-1:0] pattern_length,
  output logic                       match
);

  localparam int LW = kmve_pkg::LEN_W;

  logic [LW-1:0]          eff_len;
  logic [MAX_PATTERN-1:0] hits;
  kmve_pkg::cell_link_t   links [MAX_PATTERN];
  kmve_pkg::cell_link_t   head;

  // lengths beyond the row act as the full row
  always_comb begin
    if (pattern_length > LW'(MAX_PATTERN)) begin
      eff_len = LW'(MAX_PATTERN);
    end else begin
      eff_len = pattern_length;
    end
  end

  assign head.vld  = 1'b1;
  assign head.data = text_byte;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic          active;
    logic [LW-1:0] kidx;
    logic [7:0]    kbyte;
    kmve_pkg::cell_link_t cin;

    assign active = LW'(j) < eff_len;
    // cell j lines up with key byte len-1-j
    assign kidx   = eff_len - LW'(j) - LW'(1);
    assign kbyte  = pattern[{kidx[3:0], 3'b000} +: 8];
    assign cin    = (j == 0) ? head : links[(j == 0) ? 0 : j - 1];

    kmve_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .link_in  (cin),
      .active   (active),
      .key_byte (kbyte),
      .link_out (links[j]),
      .hit      (hits[j])
    );
  end

  // an active cell only hits on a valid byte, so the fill check is built in
  assign match = (eff_len != '0) && (&hits);

endmodule

/* rtl/core/kmve_out_buf.sv */
// ----------------------------------------------------------------------------
// kmve_out_buf
// Output register with a skid slot, so a stalled result does not stop input.
// ----------------------------------------------------------------------------
module kmve_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  kmve_pkg::result_t push_res,
  output logic              can_push,
  kmve_out_if.source        result_out
);

  logic              out_valid;
  kmve_pkg::result_t out_res;
  logic              skid_valid;
  kmve_pkg::result_t skid_res;
  logic              pop;

  assign pop      = out_valid && result_out.ready;
  assign can_push = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_res   <= push_res;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= push_res;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign result_out.valid      = out_valid;
  assign result_out.value_byte = out_res.value_byte;
  assign result_out.kind       = out_res.kind;
  assign result_out.final_res  = out_res.final_res;

endmodule

/* rtl/core/key_match_value_extract_unit.sv */
// ----------------------------------------------------------------------------
// key_match_value_extract_unit
// Takes one text byte per cycle, back to back while the skid slot is free,
// and drops spaces. Non-space bytes shift through a row of MAX_PATTERN window
// cells; every cell compares its arriving byte with its key byte in the same
// cycle, so the key search keeps pace with the stream at one byte per clock
// when input is not held. After the key is seen, non-space bytes come out as
// data results up to the first ';', which gives a done result; a text that
// ends first reports not found or unterminated value. Results pass an output
// register with a skid slot, so input keeps flowing while one result waits.
// Pattern registers must be written through the plain write port only while
// the block is idle, which it does not enforce. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module key_match_value_extract_unit #(
  parameter int MAX_PATTERN = kmve_pkg::MAX_PATTERN_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  kmve_in_if.sink                         text_in,
  kmve_out_if.source                      result_out,
  input  logic                            cfg_we,
  input  logic [kmve_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kmve_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [63:0]                pattern_low;
  logic [63:0]                pattern_high;
  logic [kmve_pkg::LEN_W-1:0] pattern_length;

  logic                 extracting, extracting_next;
  logic                 finished, finished_next;
  logic                 in_acc;
  logic                 is_space, is_semi, eot;
  logic                 match;
  logic                 can_push;
  logic                 res_push;
  kmve_pkg::result_t    res;
  kmve_pkg::cell_ctrl_t ctrl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= kmve_pkg::LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        kmve_pkg::REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        kmve_pkg::REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        kmve_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[kmve_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign text_in.ready = can_push;
  assign in_acc        = text_in.valid && text_in.ready;
  assign is_space      = text_in.text_byte == kmve_pkg::CH_SPACE;
  assign is_semi       = text_in.text_byte == kmve_pkg::CH_SEMI;
  assign eot           = text_in.end_of_text;

  // window shifts only while searching
  assign ctrl.shift = in_acc && !extracting && !finished && !is_space;
  assign ctrl.clear = in_acc && eot;

  kmve_chain #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_chain (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .text_byte      (text_in.text_byte),
    .pattern        ({pattern_high, pattern_low}),
    .pattern_length (pattern_length),
    .match          (match)
  );

  always_comb begin
    extracting_next = extracting;
    finished_next   = finished;
    res_push        = 1'b0;
    res.value_byte  = '0;
    res.kind        = kmve_pkg::KIND_DATA;
    res.final_res   = 1'b0;
    if (in_acc) begin
      if (finished) begin
        // quiet until the end of the text
      end else if (extracting) begin
        if (is_semi) begin
          res_push      = 1'b1;
          res.kind      = kmve_pkg::KIND_DONE;
          res.final_res = 1'b1;
          finished_next = 1'b1;
        end else if (eot) begin
          res_push      = 1'b1;
          res.kind      = kmve_pkg::KIND_UNTERMINATED;
          res.final_res = 1'b1;
        end else if (!is_space) begin
          res_push       = 1'b1;
          res.value_byte = text_in.text_byte;
        end
      end else begin
        if (ctrl.shift && match) begin
          extracting_next = 1'b1;
        end
        if (eot) begin
          res_push      = 1'b1;
          res.kind      = (ctrl.shift && match) ? kmve_pkg::KIND_UNTERMINATED
                                                : kmve_pkg::KIND_NOT_FOUND;
          res.final_res = 1'b1;
        end
      end
      if (eot) begin
        extracting_next = 1'b0;
        finished_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      extracting <= 1'b0;
      finished   <= 1'b0;
    end else begin
      extracting <= extracting_next;
      finished   <= finished_next;
    end
  end

  kmve_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (res_push),
    .push_res   (res),
    .can_push   (can_push),
    .result_out (result_out)
  );

`ifndef NO_ASSERTIONS
  a_clear_on_end: assert property (@(posedge clk) disable iff (rst)
    in_acc && eot |=> !extracting && !finished)
    else $error("state not cleared after final byte");

  a_finished_extracting: assert property (@(posedge clk) disable iff (rst)
    finished |-> extracting)
    else $error("done seen without a key match");

  a_nonfinal_is_data: assert property (@(posedge clk) disable iff (rst)
    res_push && !res.final_res |-> res.kind == kmve_pkg::KIND_DATA)
    else $error("non-final result that is not data");

  a_match_starts_extract: assert property (@(posedge clk) disable iff (rst)
    ctrl.shift && match && !eot |=> extracting)
    else $error("key match did not start extraction");

  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    res_push |-> in_acc && can_push)
    else $error("result without an accepted transaction");
`endif

endmodule

/* sim/tb_key_match_value_extract_unit.sv */
// ----------------------------------------------------------------------------
// tb_key_match_value_extract_unit
// Streams texts through the key match and value extract unit: plain noise,
// texts holding the key then a value closed by ';', and texts that end too
// early. A behavioural copy of the unit predicts every result, and the
// results are checked in order. Pattern settings change between phases,
// and the two sides idle and stall in one of four ways, in turn by phase.
// ----------------------------------------------------------------------------
module tb_key_match_value_extract_unit;

  localparam int MAXP          = kmve_pkg::MAX_PATTERN_DEF;
  localparam int ITEM_TARGET   = 1450;
  localparam int PHASE_ITEMS   = 110;
  localparam int SETTLE_CYCLES = 8;
  localparam int STUCK_LIMIT   = 2000;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_item_t;

  typedef enum int {
    TXT_FULL,
    TXT_NO_KEY,
    TXT_NO_SEMI,
    TXT_KEY_AT_END,
    TXT_SEMI_AT_END,
    TXT_SPACE_AT_END,
    TXT_NOISE
  } text_mode_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [kmve_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [kmve_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  kmve_in_if  text_if ();
  kmve_out_if res_if ();

  key_match_value_extract_unit #(
    .MAX_PATTERN (MAXP)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_if),
    .result_out (res_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // shadow of the pattern registers and of the per-text scan state
  logic [63:0] key_lo = '0;
  logic [63:0] key_hi = '0;
  logic [4:0]  key_len = 5'd1;
  logic [7:0]  win [MAXP];
  int          win_fill;
  bit          extracting;
  bit          finished;

  text_item_t        pending_q [$];
  kmve_pkg::result_t expected_q [$];

  int gap_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int bytes_in = 0;
  int results_checked = 0;
  int items_queued = 0;
  int texts_queued = 0;
  int settings_used = 1;
  int idle_cycles = 0;
  int kind_seen [4];

  function automatic void clear_text();
    for (int i = 0; i < MAXP; i++) win[i] = '0;
    win_fill = 0;
    extracting = 1'b0;
    finished = 1'b0;
  endfunction

  function automatic logic [7:0] key_at(input int k);
    if (k < 8) return key_lo[8*k +: 8];
    return key_hi[8*(k-8) +: 8];
  endfunction

  function automatic int key_span();
    return (key_len > MAXP) ? MAXP : int'(key_len);
  endfunction

  function automatic bit window_hit();
    int len;
    len = key_span();
    if (len == 0 || win_fill < len) return 1'b0;
    for (int k = 0; k < len; k++) begin
      if (win[len-1-k] != key_at(k)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // works out what one accepted text byte produces
  function automatic void predict_byte(input logic [7:0] b, input logic eot);
    kmve_pkg::result_t r;
    bit                have;
    r = '0;
    have = 1'b0;
    if (finished) begin
      if (eot) clear_text();
      return;
    end
    if (extracting) begin
      if (b == kmve_pkg::CH_SEMI) begin
        r.kind = kmve_pkg::KIND_DONE;
        r.final_res = 1'b1;
        have = 1'b1;
        if (eot) clear_text();
        else finished = 1'b1;
      end else if (eot) begin
        r.kind = kmve_pkg::KIND_UNTERMINATED;
        r.final_res = 1'b1;
        have = 1'b1;
        clear_text();
      end else if (b != kmve_pkg::CH_SPACE) begin
        r.value_byte = b;
        r.kind = kmve_pkg::KIND_DATA;
        have = 1'b1;
      end
    end else begin
      if (b != kmve_pkg::CH_SPACE) begin
        for (int i = MAXP - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = b;
        if (win_fill < MAXP) win_fill++;
        if (window_hit()) extracting = 1'b1;
      end
      if (eot) begin
        r.kind = extracting ? kmve_pkg::KIND_UNTERMINATED : kmve_pkg::KIND_NOT_FOUND;
        r.final_res = 1'b1;
        have = 1'b1;
        clear_text();
      end
    end
    if (have) expected_q.push_back(r);
  endfunction

  function automatic void check_result();
    kmve_pkg::result_t want;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: value %02h kind %0d final %0b",
                 res_if.value_byte, res_if.kind, res_if.final_res);
      return;
    end
    want = expected_q.pop_front();
    if (res_if.value_byte !== want.value_byte || res_if.kind !== want.kind ||
        res_if.final_res !== want.final_res) begin
      errors++;
      if (errors <= 10)
        $display({"mismatch on result %0d: expected value %02h kind %s final %0b,",
                  " got value %02h kind %0d final %0b"},
                 results_checked, want.value_byte, want.kind.name(), want.final_res,
                 res_if.value_byte, res_if.kind, res_if.final_res);
    end
    results_checked++;
    kind_seen[want.kind]++;
  endfunction

  // text byte driver
  always @(posedge clk) begin : drive_text
    text_item_t cur;
    if (rst) begin
      text_if.valid       <= 1'b0;
      text_if.text_byte   <= '0;
      text_if.end_of_text <= 1'b0;
    end else begin
      if (text_if.valid && text_if.ready) begin
        predict_byte(text_if.text_byte, text_if.end_of_text);
        bytes_in++;
      end
      if (!text_if.valid || text_if.ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          cur = pending_q.pop_front();
          text_if.valid       <= 1'b1;
          text_if.text_byte   <= cur.ch;
          text_if.end_of_text <= cur.last;
        end else begin
          text_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= stall_pct);
      if (res_if.valid && res_if.ready) check_result();
    end
  end

  always @(posedge clk) begin
    if (rst || (text_if.valid && text_if.ready) ||
        (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STUCK_LIMIT) begin
        $display("no transaction for %0d cycles, %0d results still expected",
                 STUCK_LIMIT, expected_q.size());
        $display("tb_key_match_value_extract_unit: done, errors");
        $finish;
      end
    end
  end

  function automatic void push_byte(input logic [7:0] ch, input logic last);
    text_item_t t;
    t.ch = ch;
    t.last = last;
    pending_q.push_back(t);
    items_queued++;
  endfunction

  function automatic logic [7:0] any_byte();
    int r;
    r = $urandom_range(11);
    if (r == 0 || r == 1) return kmve_pkg::CH_SPACE;
    if (r == 2) return kmve_pkg::CH_SEMI;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] value_char();
    logic [7:0] c;
    if ($urandom_range(7) == 0) return kmve_pkg::CH_SPACE;
    c = 8'($urandom_range(255));
    return (c == kmve_pkg::CH_SEMI) ? 8'h00 : c;
  endfunction

  // builds one text; an open text carries on into the next phase
  function automatic void add_text(input text_mode_t mode, input bit leave_open);
    logic [7:0] buf_q [$];
    int         n;
    int         klen;
    n = (mode == TXT_NO_KEY || mode == TXT_NOISE) ? $urandom_range(1, 16)
                                                  : $urandom_range(0, 8);
    repeat (n) buf_q.push_back(any_byte());
    if (mode != TXT_NO_KEY && mode != TXT_NOISE) begin
      klen = (key_span() == 0) ? $urandom_range(1, MAXP) : key_span();
      for (int k = 0; k < klen; k++) begin
        if ($urandom_range(7) == 0) buf_q.push_back(kmve_pkg::CH_SPACE);
        buf_q.push_back(key_at(k));
      end
      case (mode)
        TXT_FULL: begin
          repeat ($urandom_range(0, 10)) buf_q.push_back(value_char());
          buf_q.push_back(kmve_pkg::CH_SEMI);
          repeat ($urandom_range(0, 4)) buf_q.push_back(any_byte());
        end
        TXT_NO_SEMI: begin
          repeat ($urandom_range(1, 8)) buf_q.push_back(value_char());
        end
        TXT_SEMI_AT_END: begin
          repeat ($urandom_range(0, 6)) buf_q.push_back(value_char());
          buf_q.push_back(kmve_pkg::CH_SEMI);
        end
        TXT_SPACE_AT_END: begin
          repeat ($urandom_range(0, 6)) buf_q.push_back(value_char());
          buf_q.push_back(kmve_pkg::CH_SPACE);
        end
        default: ;
      endcase
    end
    for (int i = 0; i < buf_q.size(); i++)
      push_byte(buf_q[i], !leave_open && i == buf_q.size() - 1);
    texts_queued++;
  endfunction

  function automatic text_mode_t pick_mode();
    int r;
    r = $urandom_range(99);
    if (r < 45) return TXT_FULL;
    if (r < 55) return TXT_NO_SEMI;
    if (r < 63) return TXT_KEY_AT_END;
    if (r < 73) return TXT_SEMI_AT_END;
    if (r < 80) return TXT_SPACE_AT_END;
    if (r < 90) return TXT_NO_KEY;
    return TXT_NOISE;
  endfunction

  task automatic write_reg(input kmve_pkg::reg_idx_t idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      kmve_pkg::REG_PATTERN_LOW:    key_lo = val;
      kmve_pkg::REG_PATTERN_HIGH:   key_hi = val;
      kmve_pkg::REG_PATTERN_LENGTH: key_len = val[kmve_pkg::LEN_W-1:0];
      default: ;
    endcase
  endtask

  // hold the sender back until every expected result is in
  task automatic wait_quiet();
    while (pending_q.size() != 0 || text_if.valid || expected_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          phase;
    int          phase_start;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;

    text_if.valid       = 1'b0;
    text_if.text_byte   = '0;
    text_if.end_of_text = 1'b0;
    res_if.ready        = 1'b0;
    clear_text();
    for (int i = 0; i < 4; i++) kind_seen[i] = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset key is a single zero byte
    push_byte(8'h41, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(kmve_pkg::CH_SPACE, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(kmve_pkg::CH_SEMI, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(kmve_pkg::CH_SEMI, 1'b1);
    push_byte(8'h12, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(kmve_pkg::CH_SPACE, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(kmve_pkg::CH_SPACE, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(kmve_pkg::CH_SEMI, 1'b1);
    // ';' is an ordinary byte while searching
    push_byte(kmve_pkg::CH_SEMI, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(kmve_pkg::CH_SEMI, 1'b1);
    texts_queued += 7;
    wait_quiet();

    phase = 0;
    while (items_queued < ITEM_TARGET) begin
      lo  = {$urandom(), $urandom()};
      hi  = {$urandom(), $urandom()};
      len = 5'($urandom_range(1, MAXP));
      case (phase)
        0: len = 5'd16;
        1: begin
          lo  = '1;
          hi  = '1;
          len = 5'd1;
        end
        2: len = 5'd0;
        3: len = 5'd31;
        4: begin
          lo  = '0;
          hi  = '0;
          len = 5'd16;
        end
        default: if ($urandom_range(4) == 0) len = 5'($urandom_range(MAXP + 1, 31));
      endcase
      write_reg(kmve_pkg::REG_PATTERN_LOW, lo);
      write_reg(kmve_pkg::REG_PATTERN_HIGH, hi);
      write_reg(kmve_pkg::REG_PATTERN_LENGTH, 64'(len));
      cfg_we <= 1'b0;
      settings_used++;

      @(negedge clk);
      case (phase % 4)
        0: begin gap_pct <= 0;  stall_pct <= 0;  end
        1: begin gap_pct <= 79; stall_pct <= 0;  end
        2: begin gap_pct <= 0;  stall_pct <= 79; end
        default: begin gap_pct <= 36; stall_pct <= 36; end
      endcase
      phase_start = items_queued;
      while (items_queued - phase_start < PHASE_ITEMS) add_text(pick_mode(), 1'b0);
      if ($urandom_range(3) == 0) add_text(pick_mode(), 1'b1);
      wait_quiet();
      phase++;
    end

    $display("%0d text bytes in %0d texts over %0d pattern settings, %0d results checked",
             bytes_in, texts_queued, settings_used, results_checked);
    $display("results by kind: data %0d, done %0d, not found %0d, unterminated %0d",
             kind_seen[kmve_pkg::KIND_DATA], kind_seen[kmve_pkg::KIND_DONE],
             kind_seen[kmve_pkg::KIND_NOT_FOUND], kind_seen[kmve_pkg::KIND_UNTERMINATED]);
    if (errors == 0) begin
      $display("tb_key_match_value_extract_unit: done, clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_key_match_value_extract_unit: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/kmve_pkg.sv
rtl/core/kmve_in_if.sv
rtl/core/kmve_out_if.sv
rtl/core/kmve_cell.sv
rtl/core/kmve_chain.sv
rtl/core/kmve_out_buf.sv
rtl/core/key_match_value_extract_unit.sv
sim/tb_key_match_value_extract_unit.sv
